@@ sv/pivot_permutation_tracker_core_defines.svh @@
// Assertion macros shared by the permutation tracker RTL.
`ifndef PIVOT_PERMUTATION_TRACKER_CORE_DEFINES_SVH
`define PIVOT_PERMUTATION_TRACKER_CORE_DEFINES_SVH

// Implication checked in the same cycle.
`define PPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ppt_pkg.sv @@
// Shared types and constants of the permutation tracker.
package ppt_pkg;

	localparam int MAX_POSITIONS = 1024;
	localparam int POS_W = $clog2(MAX_POSITIONS);
	localparam int IDX_W = 10;
	localparam int SIZE_W = 11;
	localparam int OP_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET =
		(MAX_POSITIONS < 1024) ? SIZE_W'(MAX_POSITIONS) : SIZE_W'(1024);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_POSITIONS - 1);

	typedef enum logic [OP_W-1:0] {
		OP_IDENTITY = 2'd0,
		OP_SWAP     = 2'd1,
		OP_IMAGE    = 2'd2,
		OP_PREIMAGE = 2'd3
	} op_t;

	typedef struct packed {
		logic accept;
		logic par_clr;
		logic clr_wr;
		logic cap_fa;
		logic rd_b;
		logic wr1;
		logic wr2;
		logic cap_ans;
		logic load;
		logic from_rd;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic same;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/ppt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/ppt_ctrl.sv @@
// Controller state machine of the permutation tracker.
module ppt_ctrl
	import ppt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] opcode,
	input  sts_t            sts,
	output cmd_t            cmd,
	output logic            in_stall
);

	typedef enum logic [7:0] {
		ST_BOOT  = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CLEAR = 8'b0000_0100,
		ST_RDB   = 8'b0000_1000,
		ST_WR1   = 8'b0001_0000,
		ST_WR2   = 8'b0010_0000,
		ST_QRY   = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_BOOT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (op_t'(opcode))
						OP_IDENTITY: begin
							cmd.par_clr = 1'b1;
							state_d = ST_CLEAR;
						end
						OP_SWAP: begin
							state_d = (sts.err || sts.same) ? ST_EMIT : ST_RDB;
						end
						OP_IMAGE, OP_PREIMAGE: begin
							state_d = sts.err ? ST_EMIT : ST_QRY;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.load = sts.out_free;
					state_d = sts.out_free ? ST_IDLE : ST_EMIT;
				end
			end
			ST_RDB: begin
				cmd.cap_fa = 1'b1;
				cmd.rd_b = 1'b1;
				state_d = ST_WR1;
			end
			ST_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = ST_WR2;
			end
			ST_WR2: begin
				cmd.wr2 = 1'b1;
				cmd.load = sts.out_free;
				state_d = sts.out_free ? ST_IDLE : ST_EMIT;
			end
			ST_QRY: begin
				cmd.cap_ans = 1'b1;
				cmd.from_rd = 1'b1;
				cmd.load = sts.out_free;
				state_d = sts.out_free ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				cmd.load = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/ppt_dp.sv @@
// Datapath of the permutation tracker: tables, size, parity and result register.
module ppt_dp
	import ppt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wr,
	input  logic [SIZE_W-1:0] active_size,
	input  logic [OP_W-1:0]   opcode,
	input  logic [IDX_W-1:0]  first_index,
	input  logic [IDX_W-1:0]  second_index,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [IDX_W-1:0]  answer_index,
	output logic              parity,
	output logic              range_error
);

	logic [SIZE_W-1:0] size_q;
	logic              parity_q;
	logic [POS_W-1:0]  clr_cnt_q;
	logic              out_valid_q;

	logic [POS_W-1:0] a_q;
	logic [POS_W-1:0] b_q;
	logic             img_q;
	logic [POS_W-1:0] fa_q;
	logic [POS_W-1:0] ans_q;
	logic             err_q;
	logic [IDX_W-1:0] out_ans_q;
	logic             out_par_q;
	logic             out_err_q;

	logic             a_bad;
	logic             b_bad;
	logic             err_d;
	logic [POS_W-1:0] rd_pos;

	logic             fwd_we;
	logic [POS_W-1:0] fwd_waddr;
	logic [POS_W-1:0] fwd_wdata;
	logic [POS_W-1:0] fwd_raddr;
	logic [POS_W-1:0] fwd_rdata;
	logic             inv_we;
	logic [POS_W-1:0] inv_waddr;
	logic [POS_W-1:0] inv_wdata;
	logic [POS_W-1:0] inv_raddr;
	logic [POS_W-1:0] inv_rdata;

	assign a_bad = ({1'b0, first_index} >= size_q);
	assign b_bad = ({1'b0, second_index} >= size_q);

	always_comb begin
		case (op_t'(opcode))
			OP_IDENTITY: err_d = 1'b0;
			OP_SWAP:     err_d = a_bad || b_bad;
			OP_IMAGE:    err_d = a_bad;
			default:     err_d = b_bad;
		endcase
	end

	assign sts.err = err_d;
	assign sts.same = (first_index == second_index);
	assign sts.clr_last = (clr_cnt_q == POS_LAST);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign fwd_raddr = cmd.rd_b ? b_q :
		((op_t'(opcode) == OP_SWAP) ? POS_W'(first_index) : POS_W'(second_index));
	assign inv_raddr = POS_W'(first_index);

	always_comb begin
		fwd_we = cmd.clr_wr || cmd.wr1 || cmd.wr2;
		inv_we = fwd_we;
		if (cmd.clr_wr) begin
			fwd_waddr = clr_cnt_q;
			fwd_wdata = clr_cnt_q;
			inv_waddr = clr_cnt_q;
			inv_wdata = clr_cnt_q;
		end else if (cmd.wr1) begin
			fwd_waddr = a_q;
			fwd_wdata = fwd_rdata;
			inv_waddr = fwd_rdata;
			inv_wdata = a_q;
		end else begin
			fwd_waddr = b_q;
			fwd_wdata = fa_q;
			inv_waddr = fa_q;
			inv_wdata = b_q;
		end
	end

	ppt_ram #(
		.WIDTH(POS_W),
		.DEPTH(MAX_POSITIONS)
	) u_fwd_ram (
		.clk  (clk),
		.we   (fwd_we),
		.waddr(fwd_waddr),
		.wdata(fwd_wdata),
		.raddr(fwd_raddr),
		.rdata(fwd_rdata)
	);

	ppt_ram #(
		.WIDTH(POS_W),
		.DEPTH(MAX_POSITIONS)
	) u_inv_ram (
		.clk  (clk),
		.we   (inv_we),
		.waddr(inv_waddr),
		.wdata(inv_wdata),
		.raddr(inv_raddr),
		.rdata(inv_rdata)
	);

	assign rd_pos = img_q ? inv_rdata : fwd_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			parity_q <= 1'b0;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (32'(active_size) > 32'(MAX_POSITIONS)) begin
					size_q <= SIZE_W'(MAX_POSITIONS);
				end else begin
					size_q <= active_size;
				end
			end
			if (cmd.par_clr) begin
				parity_q <= 1'b0;
			end else if (cmd.wr1) begin
				parity_q <= ~parity_q;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= (clr_cnt_q == POS_LAST) ? '0 : clr_cnt_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q <= POS_W'(first_index);
			b_q <= POS_W'(second_index);
			img_q <= (op_t'(opcode) == OP_IMAGE);
			ans_q <= '0;
			err_q <= err_d;
		end
		if (cmd.cap_fa) begin
			fa_q <= fwd_rdata;
		end
		if (cmd.cap_ans) begin
			ans_q <= rd_pos;
		end
		if (cmd.load) begin
			out_ans_q <= IDX_W'(cmd.from_rd ? rd_pos : ans_q);
			out_par_q <= parity_q;
			out_err_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign answer_index = out_ans_q;
	assign parity = out_par_q;
	assign range_error = out_err_q;

endmodule

@@ sv/pivot_permutation_tracker_core.sv @@
// Top level of the permutation tracker with inverse table and running parity.

// The block keeps a permutation of MAX_POSITIONS entries in two RAMs, a forward
// table and an inverse table, each with one write port and one read port, and
// handles one beat at a time. A swap passes through states RDB, WR1 and WR2,
// since its two forward reads share the forward table's single read port and its
// four writes go two per table, in WR1 and then in WR2. An image or preimage
// query passes through QRY; an out-of-range index and a swap of a position with
// itself go straight to EMIT. An identity operation rewrites every entry of both
// tables, one entry per cycle, in state CLEAR. After reset the block runs the
// same pass in state BOOT with in_stall high; configuration writes are taken
// at any time but must only be issued while the block is idle.
`include "pivot_permutation_tracker_core_defines.svh"

module pivot_permutation_tracker_core
	import ppt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] active_size,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [IDX_W-1:0]  first_index,
	input  logic [IDX_W-1:0]  second_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [IDX_W-1:0]  answer_index,
	output logic              parity,
	output logic              range_error
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ppt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.sts     (sts),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	ppt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr      (cfg_valid && cfg_ready),
		.active_size (active_size),
		.opcode      (opcode),
		.first_index (first_index),
		.second_index(second_index),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.answer_index(answer_index),
		.parity      (parity),
		.range_error (range_error)
	);

	`PPT_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "accepted beat not held busy")
	`PPT_ASSERT_SAME(a_err_zero_answer, out_valid && range_error, answer_index == '0, "error result with nonzero answer")
	`PPT_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared without work in progress")

endmodule
